// ----- design/vefm_pkg.sv -----
// Package for the voxel exposed-face mask block: widths, register indexes,
// request and face codes, and the size and coordinate clamp functions.
// No dependencies.
`default_nettype none

package vefm_pkg;

  localparam int MAX_DIM     = 16;
  localparam int CW          = $clog2(MAX_DIM);
  localparam int ROW_W       = 1 << CW;
  localparam int ROW_AW      = 2 * CW;
  localparam int SIZE_W      = 5;
  localparam int POS_W       = 8;
  localparam int CELL_W      = 4;
  localparam int MASK_W      = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_W      = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int FACE_XN = 0;
  localparam int FACE_XP = 1;
  localparam int FACE_YN = 2;
  localparam int FACE_YP = 3;
  localparam int FACE_ZN = 4;
  localparam int FACE_ZP = 5;

  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_YN     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_YP     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ZN     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ZP     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LAST   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd6;

  // Largest valid coordinate along one axis for a given extent register.
  function automatic logic [CW-1:0] max_coord(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] t;
    begin
      t = size - 1'b1;
      if (size == '0) begin
        max_coord = '0;
      end else if (int'(size) > MAX_DIM) begin
        max_coord = CW'(MAX_DIM - 1);
      end else begin
        max_coord = CW'(t);
      end
    end
  endfunction

  // Clamps a signed coordinate into the range zero to lim.
  function automatic logic [CW-1:0] clamp_coord(input logic [POS_W-1:0] v,
                                                input logic [CW-1:0] lim);
    logic [POS_W-1:0] lim_ext;
    begin
      lim_ext = {{(POS_W-CW){1'b0}}, lim};
      if (v[POS_W-1]) begin
        clamp_coord = '0;
      end else if (v > lim_ext) begin
        clamp_coord = lim;
      end else begin
        clamp_coord = v[CW-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/voxel_exposed_face_mask.sv -----
// Top level of the voxel exposed-face mask block: run-time grid extents, a
// row-organized active-voxel bitmap and the sequencer that reads it.
// Depends on vefm_pkg.
`default_nettype none

// The bitmap is one single-port memory with one row per (y, z) pair and one
// bit per x, so a row read yields the voxel and both x neighbors together.
// After reset the block clears the bitmap, all 256 rows, one row a cycle,
// with in_tready low; configuration writes are taken during that time.
// A write transaction then steps through accept, row read and row write, and
// a query through accept, five row reads through the one read port, a step
// that evaluates the last face and a step that registers the result.
// The result sits in an output register
// while the block takes the next transaction, and a query finishing behind an
// untaken result waits until it is taken. Configuration may change only while
// no transaction is in progress.
module voxel_exposed_face_mask (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // pos_x [7:0], pos_y [15:8], pos_z [23:16], active_in [24], zero fill.
  input  wire  [vefm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type [0].
  input  wire  [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // cell_x [3:0], cell_y [7:4], cell_z [11:8], face_mask [17:12], zero fill.
  output logic [vefm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                 cfg_we,
  input  wire  [vefm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [vefm_pkg::SIZE_W-1:0]         cfg_wdata
);
  import vefm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUERY,
    S_WR_RD,
    S_WR
  } state_t;

  state_t             state_r;
  logic [ROW_AW-1:0]  clr_cnt_r;
  logic [STEP_W-1:0]  step_r;
  logic [SIZE_W-1:0]  size_x_r;
  logic [SIZE_W-1:0]  size_y_r;
  logic [SIZE_W-1:0]  size_z_r;
  logic [CW-1:0]      x_r;
  logic [CW-1:0]      y_r;
  logic [CW-1:0]      z_r;
  logic               act_in_r;
  logic               act_r;
  logic [MASK_W-1:0]  mask_r;
  logic               out_tvalid_r;
  logic [CELL_W-1:0]  out_x_r;
  logic [CELL_W-1:0]  out_y_r;
  logic [CELL_W-1:0]  out_z_r;
  logic [MASK_W-1:0]  out_mask_r;

  logic [ROW_W-1:0]   mem [2**ROW_AW];
  logic [ROW_W-1:0]   rd_data_r;
  logic               mem_re;
  logic               mem_we;
  logic [ROW_AW-1:0]  mem_raddr;
  logic [ROW_AW-1:0]  mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic [ROW_W-1:0]   row_upd;

  logic [CW-1:0]      xm1;
  logic [CW-1:0]      ym1;
  logic [CW-1:0]      zm1;
  logic [CW-1:0]      x_dn;
  logic [CW-1:0]      x_up;
  logic [CW-1:0]      y_dn;
  logic [CW-1:0]      y_up;
  logic [CW-1:0]      z_dn;
  logic [CW-1:0]      z_up;
  logic               in_fire;
  logic               out_load;

  assign xm1  = max_coord(size_x_r);
  assign ym1  = max_coord(size_y_r);
  assign zm1  = max_coord(size_z_r);
  assign x_dn = x_r - 1'b1;
  assign x_up = x_r + 1'b1;
  assign y_dn = y_r - 1'b1;
  assign y_up = y_r + 1'b1;
  assign z_dn = z_r - 1'b1;
  assign z_up = z_r + 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == S_QUERY) && (step_r == STEP_DONE) &&
                      (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-3*CELL_W-MASK_W){1'b0}},
                       out_mask_r, out_z_r, out_y_r, out_x_r};

  always_comb begin
    row_upd        = rd_data_r;
    row_upd[x_r]   = act_in_r;
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = {z_r, y_r};
    mem_waddr = {z_r, y_r};
    mem_wdata = row_upd;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_WR_RD: begin
        mem_re = 1'b1;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      S_QUERY: begin
        mem_re = (step_r <= STEP_ZP);
        unique case (step_r)
          STEP_YN: mem_raddr = {z_r, y_dn};
          STEP_YP: mem_raddr = {z_r, y_up};
          STEP_ZN: mem_raddr = {z_dn, y_r};
          STEP_ZP: mem_raddr = {z_up, y_r};
          default: mem_raddr = {z_r, y_r};
        endcase
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      step_r       <= '0;
      size_x_r     <= SIZE_RESET;
      size_y_r     <= SIZE_RESET;
      size_z_r     <= SIZE_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x_r <= cfg_wdata;
          REG_SIZE_Y: size_y_r <= cfg_wdata;
          REG_SIZE_Z: size_z_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            x_r      <= clamp_coord(in_tdata[POS_W-1:0], xm1);
            y_r      <= clamp_coord(in_tdata[2*POS_W-1:POS_W], ym1);
            z_r      <= clamp_coord(in_tdata[3*POS_W-1:2*POS_W], zm1);
            act_in_r <= in_tdata[3*POS_W];
            step_r   <= STEP_CENTER;
            if (in_tuser[0] == REQ_QUERY) begin
              state_r <= S_QUERY;
            end else begin
              state_r <= S_WR_RD;
            end
          end
        end
        S_WR_RD: begin
          state_r <= S_WR;
        end
        S_WR: begin
          state_r <= S_IDLE;
        end
        S_QUERY: begin
          if (step_r != STEP_DONE) begin
            step_r <= step_r + 1'b1;
          end
          unique case (step_r)
            STEP_YN: begin
              act_r                   <= rd_data_r[x_r];
              mask_r[FACE_XP:FACE_XN] <= {(x_r == xm1) || !rd_data_r[x_up],
                                          (x_r == '0) || !rd_data_r[x_dn]};
            end
            STEP_YP: mask_r[FACE_YN] <= (y_r == '0) || !rd_data_r[x_r];
            STEP_ZN: mask_r[FACE_YP] <= (y_r == ym1) || !rd_data_r[x_r];
            STEP_ZP: mask_r[FACE_ZN] <= (z_r == '0) || !rd_data_r[x_r];
            STEP_LAST: mask_r[FACE_ZP] <= (z_r == zm1) || !rd_data_r[x_r];
            STEP_DONE: begin
              if (out_load) begin
                out_x_r      <= CELL_W'(x_r);
                out_y_r      <= CELL_W'(y_r);
                out_z_r      <= CELL_W'(z_r);
                out_mask_r   <= act_r ? mask_r : '0;
                state_r      <= S_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- test/vefm_tb_pkg.sv -----
// Scoreboard for the voxel exposed-face mask testbench. It keeps a bitmap of the
// grid, predicts each query from it and checks the result stream in order.
// Depends on vefm_pkg.
package vefm_tb_pkg;
  import vefm_pkg::*;

  typedef struct {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [MASK_W-1:0] face_mask;
  } face_result_t;

  class face_scoreboard;
    bit voxel_on [MAX_DIM*MAX_DIM*MAX_DIM];
    logic [SIZE_W-1:0] size_reg [3];
    face_result_t expected_q [$];
    int errors;

    function new();
      foreach (voxel_on[i]) voxel_on[i] = 1'b0;
      foreach (size_reg[i]) size_reg[i] = SIZE_RESET;
      errors = 0;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      case (idx)
        REG_SIZE_X: size_reg[0] = val;
        REG_SIZE_Y: size_reg[1] = val;
        REG_SIZE_Z: size_reg[2] = val;
        default: ;
      endcase
    endfunction

    function int extent(int axis);
      int s;
      s = int'(size_reg[axis]);
      if (s < 1) return 1;
      if (s > MAX_DIM) return MAX_DIM;
      return s;
    endfunction

    function int clip(logic [POS_W-1:0] raw, int ext);
      int v;
      v = int'($signed(raw));
      if (v < 0) return 0;
      if (v >= ext) return ext - 1;
      return v;
    endfunction

    function bit voxel_at(int x, int y, int z);
      return voxel_on[(x + y * MAX_DIM + z * MAX_DIM * MAX_DIM) % (MAX_DIM * MAX_DIM * MAX_DIM)];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [IN_TDATA_W-1:0] data, logic req);
      int ex;
      int ey;
      int ez;
      int x;
      int y;
      int z;
      face_result_t r;
      ex = extent(0);
      ey = extent(1);
      ez = extent(2);
      x = clip(data[POS_W-1:0], ex);
      y = clip(data[2*POS_W-1:POS_W], ey);
      z = clip(data[3*POS_W-1:2*POS_W], ez);
      if (req == REQ_WRITE) begin
        voxel_on[x + y * MAX_DIM + z * MAX_DIM * MAX_DIM] = data[3*POS_W];
        return;
      end
      r.face_mask = '0;
      if (voxel_at(x, y, z)) begin
        r.face_mask[FACE_XN] = (x == 0) || !voxel_at(x - 1, y, z);
        r.face_mask[FACE_XP] = (x == ex - 1) || !voxel_at(x + 1, y, z);
        r.face_mask[FACE_YN] = (y == 0) || !voxel_at(x, y - 1, z);
        r.face_mask[FACE_YP] = (y == ey - 1) || !voxel_at(x, y + 1, z);
        r.face_mask[FACE_ZN] = (z == 0) || !voxel_at(x, y, z - 1);
        r.face_mask[FACE_ZP] = (z == ez - 1) || !voxel_at(x, y, z + 1);
      end
      r.cell_x = CELL_W'(x);
      r.cell_y = CELL_W'(y);
      r.cell_z = CELL_W'(z);
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      face_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("cell_x", 8'(e.cell_x), 8'(data[CELL_W-1:0]));
      compare_field("cell_y", 8'(e.cell_y), 8'(data[2*CELL_W-1:CELL_W]));
      compare_field("cell_z", 8'(e.cell_z), 8'(data[3*CELL_W-1:2*CELL_W]));
      compare_field("face_mask", 8'(e.face_mask), 8'(data[3*CELL_W +: MASK_W]));
    endfunction
  endclass

endpackage

// ----- test/tb_top.sv -----
// Top of the voxel exposed-face mask testbench: clock, reset, stream drivers with
// random idling, configuration phases and the watchdog.
// Depends on vefm_pkg, vefm_tb_pkg and the voxel_exposed_face_mask RTL.
module tb_top;
  import vefm_pkg::*;
  import vefm_tb_pkg::*;

  localparam int IDLE_LIMIT      = 3000;
  localparam int LONG_HOLD       = 400;
  localparam int SETTLE          = 16;
  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 145;

  localparam logic [POS_W-1:0] POS_MIN  = 8'h80;
  localparam logic [POS_W-1:0] POS_MAX  = 8'h7F;
  localparam logic [POS_W-1:0] POS_NEG1 = 8'hFF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SIZE_W-1:0]      cfg_wdata;

  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  face_scoreboard faces = new();

  voxel_exposed_face_mask dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates mostly land in or just outside the grid, or in a small corner
  // cluster so that neighbors meet even on a large grid.
  function automatic logic [POS_W-1:0] pick_pos(input int ext);
    int r;
    int lim;
    r = $urandom_range(0, 99);
    lim = (ext < 4) ? ext : 4;
    if (r < 45) return POS_W'($urandom_range(0, ext + 1) - 1);
    if (r < 75) return POS_W'($urandom_range(0, lim - 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic offer(input logic req, input logic [POS_W-1:0] px,
                       input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz,
                       input logic act, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_TDATA_W - 3*POS_W - 1){1'b0}}, act, pz, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_item();
    logic req;
    logic act;
    int g;
    req = ($urandom_range(0, 1) == 1) ? REQ_QUERY : REQ_WRITE;
    act = ($urandom_range(0, 99) < 65);
    g = no_idle ? 0 : pick_gap();
    offer(req, pick_pos(faces.extent(0)), pick_pos(faces.extent(1)),
          pick_pos(faces.extent(2)), act, g);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (faces.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) faces.set_size(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) faces.note_input(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) faces.check_result(out_tdata);
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int k;
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    write_size(REG_SIZE_X, SIZE_RESET);
    write_size(REG_SIZE_Y, SIZE_RESET);
    write_size(REG_SIZE_Z, SIZE_RESET);

    offer(REQ_QUERY, 8'd0, 8'd0, 8'd0, 1'b1, 0);
    offer(REQ_WRITE, 8'd0, 8'd0, 8'd0, 1'b1, 0);
    offer(REQ_QUERY, 8'd0, 8'd0, 8'd0, 1'b0, 0);
    offer(REQ_WRITE, 8'd1, 8'd0, 8'd0, 1'b1, 0);
    offer(REQ_QUERY, POS_MIN, POS_NEG1, POS_MIN, 1'b0, 0);
    offer(REQ_WRITE, POS_MAX, POS_MAX, POS_MAX, 1'b1, 0);
    offer(REQ_QUERY, 8'd15, 8'd15, 8'd15, 1'b0, 0);
    offer(REQ_WRITE, 8'd14, 8'd15, 8'd15, 1'b1, 0);
    offer(REQ_WRITE, 8'd15, 8'd14, 8'd15, 1'b1, 0);
    offer(REQ_WRITE, 8'd15, 8'd15, 8'd14, 1'b1, 0);
    offer(REQ_QUERY, POS_MAX, 8'd16, POS_MAX, 1'b1, 0);
    offer(REQ_WRITE, 8'd8, 8'd8, 8'd8, 1'b1, 0);
    offer(REQ_WRITE, 8'd7, 8'd8, 8'd8, 1'b1, 0);
    offer(REQ_WRITE, 8'd9, 8'd8, 8'd8, 1'b1, 0);
    offer(REQ_WRITE, 8'd8, 8'd7, 8'd8, 1'b1, 0);
    offer(REQ_WRITE, 8'd8, 8'd9, 8'd8, 1'b1, 0);
    offer(REQ_WRITE, 8'd8, 8'd8, 8'd7, 1'b1, 0);
    offer(REQ_WRITE, 8'd8, 8'd8, 8'd9, 1'b1, 0);
    offer(REQ_QUERY, 8'd8, 8'd8, 8'd8, 1'b0, 0);
    offer(REQ_QUERY, 8'd9, 8'd8, 8'd8, 1'b0, 0);
    offer(REQ_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 0);
    offer(REQ_QUERY, 8'd0, 8'd0, 8'd0, 1'b1, 0);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin sx = 5'd16; sy = 5'd16; sz = 5'd16; end
        1: begin sx = 5'd1;  sy = 5'd1;  sz = 5'd1;  end
        2: begin sx = 5'd0;  sy = 5'd0;  sz = 5'd0;  end
        3: begin sx = 5'd31; sy = 5'd17; sz = 5'd16; end
        4: begin sx = 5'd2;  sy = 5'd2;  sz = 5'd2;  end
        5: begin sx = 5'd3;  sy = 5'd4;  sz = 5'd5;  end
        6: begin sx = 5'd16; sy = 5'd1;  sz = 5'd8;  end
        7: begin sx = 5'd2;  sy = 5'd16; sz = 5'd3;  end
        default: begin
          sx = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 31))
                                           : SIZE_W'($urandom_range(1, 5));
          sy = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 31))
                                           : SIZE_W'($urandom_range(1, 5));
          sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 31))
                                           : SIZE_W'($urandom_range(1, 5));
        end
      endcase
      write_size(REG_SIZE_X, sx);
      write_size(REG_SIZE_Y, sy);
      write_size(REG_SIZE_Z, sz);
      no_idle = (ph == 4 || ph == 8);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 3 && k == 40) hold_req = 1'b1;
        if (ph == 6 && k == 60) wait_idle();
        random_item();
      end
    end
    wait_idle();

    if (faces.errors == 0 && faces.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/vefm_pkg.sv
design/voxel_exposed_face_mask.sv
test/vefm_tb_pkg.sv
test/tb_top.sv
